/* src/cpam_pkg.sv */
// cpam_pkg: shared types and constants for the chart point autoscale mapper
// transaction payload structs, command codes, register map and geometry constants
// no dependencies
`default_nettype none

package cpam_pkg;

   // command codes of an input transaction
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_RENDER = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // register map, index = paddr / 4
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] REG_X_DOMAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_DOMAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDGET_LEFT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDGET_TOP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDGET_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WIDGET_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AXES_ON       = 3'd6;

   // plot geometry
   localparam logic [15:0] AXIS_MARGIN = 16'd2;
   localparam logic [15:0] MIN_SIZE    = 16'd4;

   typedef struct packed {
      logic [1:0]          command;
      logic                x_given;
      logic signed [15:0]  x_value;
      logic signed [15:0]  y_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0]  screen_x;
      logic signed [15:0]  screen_y;
      logic                last_point;
   } rsp_type;

endpackage : cpam_pkg

`default_nettype wire

/* src/cpam_ram.sv */
// cpam_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cpam_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : cpam_ram

`default_nettype wire

/* src/chart_point_autoscale_mapper.sv */
// chart_point_autoscale_mapper: point store with autoscaled linear mapping to screen pixels
// depends on cpam_pkg and cpam_ram
//
// Load and clear transactions never raise busy, so loads may arrive on every cycle
// while busy is low. A render raises busy and walks the stored points one at a time:
// for each point one ram read, then per axis a clamp and subtract step, a multiply and
// 16 divide steps of the shared restoring divider. Each result appears on rsp_data for a
// single cycle with rsp_strobe high; the receiver cannot stall it. The final result of a
// render carries last_point. A render with an empty store or a widget narrower or
// shorter than 4 pixels emits nothing and does not raise busy. The point store needs no
// clearing pass after reset.
`default_nettype none

module chart_point_autoscale_mapper
   import cpam_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command transactions
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   // results
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data,
   // configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PREP,
      ST_MUL,
      ST_DIV
   } state_type;

   // configuration registers
   logic [31:0]        x_domain_ff, x_domain_in;
   logic [31:0]        y_domain_ff, y_domain_in;
   logic signed [15:0] widget_left_ff, widget_left_in;
   logic signed [15:0] widget_top_ff, widget_top_in;
   logic [15:0]        widget_width_ff, widget_width_in;
   logic [15:0]        widget_height_ff, widget_height_in;
   logic               axes_on_ff, axes_on_in;

   // store bookkeeping
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [15:0] x_min_ff, x_min_in, x_max_ff, x_max_in;
   logic signed [15:0] y_min_ff, y_min_in, y_max_ff, y_max_in;

   // render sequencer and shared datapath
   state_type          state_ff, state_in;
   logic               axis_ff, axis_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [3:0]         step_ff, step_in;
   logic [15:0]        num_ff, num_in;
   logic [15:0]        den_ff, den_in;
   logic [15:0]        span_ff, span_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;
   logic signed [15:0] sx_ff, sx_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // ram ports
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [31:0]        wr_data;
   logic               rd_en;
   logic [31:0]        rd_data;

   logic               accept;
   logic               csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   // axis ranges
   logic signed [15:0] dom_x_lo, dom_x_hi, dom_y_lo, dom_y_hi;
   logic signed [15:0] x_lo, x_hi, y_lo, y_hi;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      dom_x_lo = x_domain_ff[15:0];
      dom_x_hi = x_domain_ff[31:16];
      dom_y_lo = y_domain_ff[15:0];
      dom_y_hi = y_domain_ff[31:16];
      if (dom_x_lo != dom_x_hi) begin
         x_lo = dom_x_lo;
         x_hi = dom_x_hi;
      end else begin
         x_lo = x_min_ff;
         x_hi = (x_min_ff == x_max_ff) ? x_min_ff + 16'sd1 : x_max_ff;
      end
      if (dom_y_lo != dom_y_hi) begin
         y_lo = dom_y_lo;
         y_hi = dom_y_hi;
      end else begin
         y_lo = y_min_ff;
         y_hi = (y_min_ff == y_max_ff) ? y_min_ff + 16'sd1 : y_max_ff;
      end
   end

   always_comb begin
      case (csr_idx)
         REG_X_DOMAIN:      prdata = x_domain_ff;
         REG_Y_DOMAIN:      prdata = y_domain_ff;
         REG_WIDGET_LEFT:   prdata = {16'd0, widget_left_ff};
         REG_WIDGET_TOP:    prdata = {16'd0, widget_top_ff};
         REG_WIDGET_WIDTH:  prdata = {16'd0, widget_width_ff};
         REG_WIDGET_HEIGHT: prdata = {16'd0, widget_height_ff};
         REG_AXES_ON:       prdata = {31'd0, axes_on_ff};
         default:           prdata = 32'd0;
      endcase
   end

   cpam_ram #(
      .WIDTH (32),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      logic signed [15:0] px_load;
      logic signed [15:0] d;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      logic signed [15:0] d_clamp;
      logic signed [16:0] num_s;
      logic signed [16:0] den_s;
      logic [16:0]        num_abs;
      logic [16:0]        den_abs;
      logic [15:0]        margin;
      logic [31:0]        prod;
      logic [16:0]        trial;
      logic               take;
      logic               last;

      // defaults: hold
      x_domain_in      = x_domain_ff;
      y_domain_in      = y_domain_ff;
      widget_left_in   = widget_left_ff;
      widget_top_in    = widget_top_ff;
      widget_width_in  = widget_width_ff;
      widget_height_in = widget_height_ff;
      axes_on_in       = axes_on_ff;
      count_in         = count_ff;
      x_min_in         = x_min_ff;
      x_max_in         = x_max_ff;
      y_min_in         = y_min_ff;
      y_max_in         = y_max_ff;
      state_in         = state_ff;
      axis_in          = axis_ff;
      idx_in           = idx_ff;
      step_in          = step_ff;
      num_in           = num_ff;
      den_in           = den_ff;
      span_in          = span_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      sx_in            = sx_ff;
      rsp_strobe_in    = 1'b0;
      rsp_data_in      = rsp_data_ff;
      wr_en            = 1'b0;
      wr_addr          = count_ff[IDX_W-1:0];
      px_load          = req_data.x_given ? req_data.x_value : 16'(count_ff);
      wr_data          = {req_data.y_value, px_load};
      rd_en            = 1'b0;

      margin  = axes_on_ff ? AXIS_MARGIN : 16'd0;
      d       = axis_ff ? rd_data[31:16] : rd_data[15:0];
      lo      = axis_ff ? y_lo : x_lo;
      hi      = axis_ff ? y_hi : x_hi;
      d_clamp = (d < lo) ? lo : d;
      d_clamp = (d_clamp > hi) ? hi : d_clamp;
      // y is flipped so larger values land higher up
      num_s   = axis_ff ? (17'(hi) - 17'(d_clamp)) : (17'(d_clamp) - 17'(lo));
      den_s   = 17'(hi) - 17'(lo);
      num_abs = num_s[16] ? 17'(-num_s) : 17'(num_s);
      den_abs = den_s[16] ? 17'(-den_s) : 17'(den_s);
      prod    = num_ff * span_ff;
      trial   = {rem_ff, quo_ff[15]};
      take    = (trial >= {1'b0, den_ff});
      last    = ((idx_ff + CNT_W'(1)) == count_ff);

      if (csr_write) begin
         case (csr_idx)
            REG_X_DOMAIN:      x_domain_in      = pwdata;
            REG_Y_DOMAIN:      y_domain_in      = pwdata;
            REG_WIDGET_LEFT:   widget_left_in   = pwdata[15:0];
            REG_WIDGET_TOP:    widget_top_in    = pwdata[15:0];
            REG_WIDGET_WIDTH:  widget_width_in  = pwdata[15:0];
            REG_WIDGET_HEIGHT: widget_height_in = pwdata[15:0];
            REG_AXES_ON:       axes_on_in       = pwdata[0];
            default:           ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_LOAD: begin
                     if (count_ff != CNT_W'(MAX_POINTS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == '0) begin
                           x_min_in = px_load;
                           x_max_in = px_load;
                           y_min_in = req_data.y_value;
                           y_max_in = req_data.y_value;
                        end else begin
                           if (px_load < x_min_ff) x_min_in = px_load;
                           if (px_load > x_max_ff) x_max_in = px_load;
                           if (req_data.y_value < y_min_ff) y_min_in = req_data.y_value;
                           if (req_data.y_value > y_max_ff) y_max_in = req_data.y_value;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     x_min_in = '0;
                     x_max_in = '0;
                     y_min_in = '0;
                     y_max_in = '0;
                  end
                  CMD_RENDER: begin
                     if (widget_width_ff >= MIN_SIZE && widget_height_ff >= MIN_SIZE &&
                         count_ff != '0) begin
                        idx_in   = '0;
                        axis_in  = 1'b0;
                        state_in = ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            num_in   = num_abs[15:0];
            den_in   = den_abs[15:0];
            span_in  = (axis_ff ? widget_height_ff : widget_width_ff) - margin - 16'd1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // quotient never exceeds span, so the top half starts below the divisor
            rem_in   = prod[31:16];
            quo_in   = prod[15:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = take ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
            quo_in  = {quo_ff[14:0], take};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               if (!axis_ff) begin
                  sx_in    = widget_left_ff + margin + quo_in;
                  axis_in  = 1'b1;
                  state_in = ST_PREP;
               end else begin
                  rsp_strobe_in          = 1'b1;
                  rsp_data_in.screen_x   = sx_ff;
                  rsp_data_in.screen_y   = widget_top_ff + quo_in;
                  rsp_data_in.last_point = last;
                  axis_in                = 1'b0;
                  if (last) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_domain_in_reset: begin
            x_domain_ff      <= '0;
            y_domain_ff      <= '0;
            widget_left_ff   <= '0;
            widget_top_ff    <= '0;
            widget_width_ff  <= '0;
            widget_height_ff <= '0;
            axes_on_ff       <= 1'b1;
            count_ff         <= '0;
            x_min_ff         <= '0;
            x_max_ff         <= '0;
            y_min_ff         <= '0;
            y_max_ff         <= '0;
            state_ff         <= ST_IDLE;
            axis_ff          <= 1'b0;
            idx_ff           <= '0;
            step_ff          <= '0;
            rsp_strobe_ff    <= 1'b0;
         end
      end else begin
         x_domain_ff      <= x_domain_in;
         y_domain_ff      <= y_domain_in;
         widget_left_ff   <= widget_left_in;
         widget_top_ff    <= widget_top_in;
         widget_width_ff  <= widget_width_in;
         widget_height_ff <= widget_height_in;
         axes_on_ff       <= axes_on_in;
         count_ff         <= count_in;
         x_min_ff         <= x_min_in;
         x_max_ff         <= x_max_in;
         y_min_ff         <= y_min_in;
         y_max_ff         <= y_max_in;
         state_ff         <= state_in;
         axis_ff          <= axis_in;
         idx_ff           <= idx_in;
         step_ff          <= step_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
      num_ff      <= num_in;
      den_ff      <= den_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sx_ff       <= sx_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // store never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   // the point count, the x minimum and the y maximum stay put for a whole render
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(count_ff) && $stable(x_min_ff) && $stable(y_max_ff))
      else $error("store changed during render");

   // a non-final result leaves the render running, the final one ends it
   a_mid_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_point |-> busy)
      else $error("render stopped before its last result");

   a_last_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_point |-> !busy)
      else $error("render still busy after its last result");

   // results never come back to back
   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back results");
`endif

endmodule : chart_point_autoscale_mapper

`default_nettype wire
